[sv/aps_pkg.sv]
`timescale 1ns / 1ps

package aps_pkg;

    // default build values
    localparam int DEF_PATTERN_BYTES = 16;
    localparam int DEF_PATCH_BYTES   = 8;
    localparam int DEF_MAX_SHIFT     = 16;
    localparam int DEF_POSITION_BITS = 32;

    // candidate spacing
    localparam int STRIDE = 4;

    // configuration port
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATCH_BYTES  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATCH_LEN    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PATCH_SHIFT  = 3'd5;

    localparam logic [4:0] RST_PATTERN_LEN = 5'd4;
    localparam logic [3:0] RST_PATCH_LEN   = 4'd4;

    // match counter
    localparam int               COUNT_W   = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] pattern_low;
        logic [CFG_DATA_W-1:0] pattern_high;
        logic [4:0]            pattern_len;
        logic [CFG_DATA_W-1:0] patch_bytes;
        logic [3:0]            patch_len;
        logic [4:0]            patch_shift;
    } cfg_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               out_last;
        logic [COUNT_W-1:0] match_count;
        logic               found;
    } out_item_t;

    // one window step as issued by the top level
    typedef struct packed {
        logic     advance;
        logic     take;
        in_item_t item;
    } step_t;

    typedef struct packed {
        logic draining;
        logic at_capacity;
    } win_status_t;

    typedef struct packed {
        logic      emit;
        out_item_t item;
    } win_result_t;

endpackage

[sv/aps_stream_if.sv]
`timescale 1ns / 1ps

interface aps_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/aps_cfg_regs.sv]
`timescale 1ns / 1ps

module aps_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [aps_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [aps_pkg::CFG_DATA_W-1:0]  wr_data,
    output aps_pkg::cfg_t                cfg
);
    import aps_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_PATTERN_LOW:  cfg_next.pattern_low  = wr_data;
                REG_PATTERN_HIGH: cfg_next.pattern_high = wr_data;
                REG_PATTERN_LEN:  cfg_next.pattern_len  = wr_data[4:0];
                REG_PATCH_BYTES:  cfg_next.patch_bytes  = wr_data;
                REG_PATCH_LEN:    cfg_next.patch_len    = wr_data[3:0];
                REG_PATCH_SHIFT:  cfg_next.patch_shift  = wr_data[4:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_low  <= '0;
            cfg_reg.pattern_high <= '0;
            cfg_reg.pattern_len  <= RST_PATTERN_LEN;
            cfg_reg.patch_bytes  <= '0;
            cfg_reg.patch_len    <= RST_PATCH_LEN;
            cfg_reg.patch_shift  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/aps_window.sv]
`timescale 1ns / 1ps

module aps_window #(
    parameter int PATTERN_BYTES = aps_pkg::DEF_PATTERN_BYTES,
    parameter int PATCH_BYTES   = aps_pkg::DEF_PATCH_BYTES,
    parameter int MAX_SHIFT     = aps_pkg::DEF_MAX_SHIFT,
    parameter int POSITION_BITS = aps_pkg::DEF_POSITION_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  aps_pkg::cfg_t        cfg,
    input  aps_pkg::step_t       step,
    output aps_pkg::win_status_t status,
    output aps_pkg::win_result_t result
);
    import aps_pkg::*;

    localparam int WIN    = (PATTERN_BYTES > MAX_SHIFT + PATCH_BYTES) ?
                            PATTERN_BYTES : MAX_SHIFT + PATCH_BYTES;
    localparam int FILL_W = $clog2(WIN + 1);
    localparam int CMP_W  = $clog2(WIN + 32) + 1;
    localparam int PW     = POSITION_BITS;
    localparam int EXT_W  = POSITION_BITS + CMP_W;

    logic [7:0]         window_reg [WIN];
    logic [7:0]         window_next [WIN];
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [PW-1:0]      cand_reg, cand_next;
    logic [COUNT_W-1:0] matches_reg, matches_next;
    logic               draining_reg, draining_next;

    logic [7:0]         w_ins [WIN];
    logic [7:0]         w_pat [WIN];
    logic [FILL_W-1:0]  f1;
    logic [PW-1:0]      pos1;
    logic [CMP_W-1:0]   plen, pl, sh, span, adv, f1_ext;
    logic [PW-1:0]      q, cand_upd;
    logic               at_cand, fits, bytes_ok, hit;
    logic               pop, last_pop, last_flag;
    logic [COUNT_W-1:0] matches_upd;

    function automatic logic [7:0] pat_byte(input logic [CFG_DATA_W-1:0] lo,
                                            input logic [CFG_DATA_W-1:0] hi,
                                            input int k);
        logic [2*CFG_DATA_W-1:0] s;
        s = {hi, lo} >> (8 * k);
        return s[7:0];
    endfunction

    function automatic logic [7:0] fix_byte(input logic [CFG_DATA_W-1:0] bytes,
                                            input logic [CMP_W-1:0] idx);
        logic [CFG_DATA_W-1:0] s;
        s = bytes >> {idx[2:0], 3'b000};
        return (idx < CMP_W'(CFG_DATA_W / 8)) ? s[7:0] : 8'h00;
    endfunction

    // clamped lengths
    always_comb
    begin
        plen = (CMP_W'(cfg.pattern_len) > CMP_W'(PATTERN_BYTES)) ?
               CMP_W'(PATTERN_BYTES) : CMP_W'(cfg.pattern_len);
        pl   = (CMP_W'(cfg.patch_len) > CMP_W'(PATCH_BYTES)) ?
               CMP_W'(PATCH_BYTES) : CMP_W'(cfg.patch_len);
        sh   = (CMP_W'(cfg.patch_shift) > CMP_W'(MAX_SHIFT)) ?
               CMP_W'(MAX_SHIFT) : CMP_W'(cfg.patch_shift);
        span = sh + pl;
        adv  = (span == '0) ? CMP_W'(STRIDE) : span;
    end

    // append the new byte behind the held ones
    always_comb
    begin
        for (int j = 0; j < WIN; j++)
        begin
            w_ins[j] = (step.take && FILL_W'(j) == fill_reg) ? step.item.in_byte :
                       window_reg[j];
        end
        f1   = step.take ? fill_reg + FILL_W'(1) : fill_reg;
        pos1 = step.take ? pos_reg + PW'(1) : pos_reg;
    end

    // candidate test on the oldest held byte
    always_comb
    begin
        f1_ext   = CMP_W'(f1);
        q        = PW'(EXT_W'(pos1) - EXT_W'(f1));
        at_cand  = (cand_reg == q);
        fits     = (plen <= f1_ext) && (span <= f1_ext);
        bytes_ok = 1'b1;
        for (int k = 0; k < PATTERN_BYTES; k++)
        begin
            if (CMP_W'(k) < plen &&
                w_ins[k] != pat_byte(cfg.pattern_low, cfg.pattern_high, k))
            begin
                bytes_ok = 1'b0;
            end
        end
        hit = at_cand && fits && bytes_ok;

        if (!at_cand)
            cand_upd = cand_reg;
        else if (hit)
            cand_upd = PW'(EXT_W'(q) + EXT_W'(adv));
        else
            cand_upd = PW'(EXT_W'(q) + EXT_W'(STRIDE));

        matches_upd = (hit && matches_reg != COUNT_MAX) ? matches_reg + COUNT_W'(1) :
                      matches_reg;

        for (int j = 0; j < WIN; j++)
        begin
            if (hit && CMP_W'(j) >= sh && CMP_W'(j) < span)
                w_pat[j] = fix_byte(cfg.patch_bytes, CMP_W'(j) - sh);
            else
                w_pat[j] = w_ins[j];
        end
    end

    always_comb
    begin
        last_pop  = draining_reg || (step.take && step.item.in_last);
        pop       = step.advance &&
                    (draining_reg ||
                     (step.take && (step.item.in_last || f1 == FILL_W'(WIN))));
        last_flag = last_pop && (f1 == FILL_W'(1));
    end

    always_comb
    begin
        result.emit              = pop;
        result.item.out_byte     = w_pat[0];
        result.item.out_last     = last_flag;
        result.item.match_count  = last_flag ? matches_upd : '0;
        result.item.found        = last_flag && (matches_upd != '0);
        status.draining          = draining_reg;
        status.at_capacity       = (fill_reg == FILL_W'(WIN - 1));
    end

    // control state
    always_comb
    begin
        fill_next     = fill_reg;
        pos_next      = pos_reg;
        cand_next     = cand_reg;
        matches_next  = matches_reg;
        draining_next = draining_reg;
        if (step.advance)
        begin
            if (!pop)
            begin
                fill_next = f1;
                pos_next  = pos1;
            end
            else if (last_flag)
            begin
                // image done, start over
                fill_next     = '0;
                pos_next      = '0;
                cand_next     = '0;
                matches_next  = '0;
                draining_next = 1'b0;
            end
            else
            begin
                fill_next     = f1 - FILL_W'(1);
                pos_next      = pos1;
                cand_next     = cand_upd;
                matches_next  = matches_upd;
                draining_next = last_pop;
            end
        end
    end

    // byte window
    always_comb
    begin
        for (int j = 0; j < WIN; j++)
            window_next[j] = window_reg[j];
        if (step.advance)
        begin
            if (!pop)
            begin
                for (int j = 0; j < WIN; j++)
                    window_next[j] = w_ins[j];
            end
            else
            begin
                for (int j = 0; j < WIN - 1; j++)
                    window_next[j] = w_pat[j + 1];
                window_next[WIN - 1] = 8'h00;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            pos_reg      <= '0;
            cand_reg     <= '0;
            matches_reg  <= '0;
            draining_reg <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            pos_reg      <= pos_next;
            cand_reg     <= cand_next;
            matches_reg  <= matches_next;
            draining_reg <= draining_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < WIN; j++)
            window_reg[j] <= window_next[j];
    end

endmodule

[sv/aligned_pattern_patch_stream.sv]
`timescale 1ns / 1ps

// channel   dir  transaction payload
// raw       in   in_byte, in_last                        (one image byte)
// patched   out  out_byte, out_last, match_count, found  (one image byte)
// wr_*      in   wr_index, wr_data                       (register write, no handshake)
//
// one byte per cycle in and out in steady state while patched is not stalled; a
// byte leaves after the window delay (max(PATTERN_BYTES, MAX_SHIFT + PATCH_BYTES)
// bytes, 24 by default) and passes through the input and output registers.
// the last byte of an image flushes the window: as many output transactions as
// bytes were held (up to the window depth), one per cycle unless patched stalls;
// raw takes at most one more byte into the input register meanwhile.
// the window compare, patch and shift are one pass of logic between the input
// register and the output register.
// rst_n clears the stream state and loads register defaults; a stall on patched
// holds the output register while the input register can still take one byte.

module aligned_pattern_patch_stream #(
    parameter int PATTERN_BYTES = aps_pkg::DEF_PATTERN_BYTES,
    parameter int PATCH_BYTES   = aps_pkg::DEF_PATCH_BYTES,
    parameter int MAX_SHIFT     = aps_pkg::DEF_MAX_SHIFT,
    parameter int POSITION_BITS = aps_pkg::DEF_POSITION_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    aps_stream_if.sink                      raw,
    aps_stream_if.source                    patched,
    input  logic                            wr_en,
    input  logic [aps_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [aps_pkg::CFG_DATA_W-1:0]  wr_data
);
    import aps_pkg::*;

    cfg_t        cfg;
    step_t       step;
    win_status_t status;
    win_result_t result;

    // input register
    logic     in_valid_reg;
    in_item_t in_item_reg;

    // output register
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic out_free;
    logic would_emit;
    logic go;

    aps_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    aps_window #(
        .PATTERN_BYTES (PATTERN_BYTES),
        .PATCH_BYTES   (PATCH_BYTES),
        .MAX_SHIFT     (MAX_SHIFT),
        .POSITION_BITS (POSITION_BITS)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .status (status),
        .result (result)
    );

    // a step that fills the window needs no output slot
    always_comb
    begin
        out_free   = !out_valid_reg || patched.ready;
        would_emit = status.draining || in_item_reg.in_last || status.at_capacity;
        go         = (status.draining || in_valid_reg) && (out_free || !would_emit);

        step.advance = go;
        step.take    = go && !status.draining;
        step.item    = in_item_reg;
    end

    assign raw.ready = !in_valid_reg || step.take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (raw.valid && raw.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step.take)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (raw.valid && raw.ready)
            in_item_reg <= raw.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go && result.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (patched.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && result.emit)
            out_item_reg <= result.item;
    end

    assign patched.valid = out_valid_reg;
    assign patched.data  = out_item_reg;

endmodule

[sv/aps_checker.sv]
`timescale 1ns / 1ps

module aps_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input aps_pkg::out_item_t out_item
);
    import aps_pkg::*;

    // count fields only travel with the final byte
    a_count_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.out_last |-> out_item.match_count == '0 && !out_item.found)
        else $error("count fields set on a non-final byte");

    a_found_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.out_last |-> out_item.found == (out_item.match_count != '0))
        else $error("found flag disagrees with match count");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_item))
        else $error("output payload changed while stalled");

endmodule

bind aligned_pattern_patch_stream aps_checker u_aps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (patched.valid),
    .out_ready (patched.ready),
    .out_item  (patched.data)
);
